@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL; they compile away when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed: invariant");

// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/thcc_pkg.sv @@
package thcc_pkg;

	// APB address width: seven 32-bit registers at byte addresses 4*i
	localparam int ADDR_W = 5;

	typedef enum logic [1:0] {
		SEL_OFF  = 2'd0,
		SEL_AUTO = 2'd1,
		SEL_HEAT = 2'd2,
		SEL_COOL = 2'd3
	} sel_mode_t;

	typedef enum logic [1:0] {
		OP_UNDEF = 2'd0,
		OP_HEAT  = 2'd1,
		OP_COOL  = 2'd2
	} op_mode_t;

	typedef enum logic [2:0] {
		REG_SELECTED_MODE = 3'd0,
		REG_UPPER_HYST    = 3'd1,
		REG_UPPER_SWITCH  = 3'd2,
		REG_LOWER_HYST    = 3'd3,
		REG_LOWER_SWITCH  = 3'd4,
		REG_RESTART_WAIT  = 3'd5,
		REG_FAN_WAIT      = 3'd6
	} reg_idx_t;

	// reset values of the configuration registers
	localparam logic [1:0]         RST_SELECTED_MODE = 2'd2;
	localparam logic signed [11:0] RST_UPPER_HYST    = 12'sd352;
	localparam logic signed [11:0] RST_UPPER_SWITCH  = 12'sd368;
	localparam logic signed [11:0] RST_LOWER_HYST    = 12'sd288;
	localparam logic signed [11:0] RST_LOWER_SWITCH  = 12'sd272;
	localparam logic [31:0]        RST_RESTART_WAIT  = 32'd120000;
	localparam logic [31:0]        RST_FAN_WAIT      = 32'd300000;

	typedef struct packed {
		sel_mode_t          selected_mode;
		logic signed [11:0] upper_hysteresis_temp;
		logic signed [11:0] upper_switch_temp;
		logic signed [11:0] lower_hysteresis_temp;
		logic signed [11:0] lower_switch_temp;
		logic [31:0]        restart_wait_ticks;
		logic [31:0]        fan_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic signed [11:0] chamber_temp;
		logic [31:0]        now_ticks;
	} item_t;

	typedef struct packed {
		op_mode_t operating_mode;
		logic     fan_on;
		logic     cooler_on;
		logic     heater_on;
	} result_t;

endpackage

@@ rtl/thcc_regs.sv @@
module thcc_regs
	import thcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.selected_mode         <= sel_mode_t'(RST_SELECTED_MODE);
			cfg_q.upper_hysteresis_temp <= RST_UPPER_HYST;
			cfg_q.upper_switch_temp     <= RST_UPPER_SWITCH;
			cfg_q.lower_hysteresis_temp <= RST_LOWER_HYST;
			cfg_q.lower_switch_temp     <= RST_LOWER_SWITCH;
			cfg_q.restart_wait_ticks    <= RST_RESTART_WAIT;
			cfg_q.fan_wait_ticks        <= RST_FAN_WAIT;
		end else if (wr_en) begin
			unique case (idx)
				REG_SELECTED_MODE: cfg_q.selected_mode <= sel_mode_t'(pwdata[1:0]);
				REG_UPPER_HYST:    cfg_q.upper_hysteresis_temp <= pwdata[11:0];
				REG_UPPER_SWITCH:  cfg_q.upper_switch_temp <= pwdata[11:0];
				REG_LOWER_HYST:    cfg_q.lower_hysteresis_temp <= pwdata[11:0];
				REG_LOWER_SWITCH:  cfg_q.lower_switch_temp <= pwdata[11:0];
				REG_RESTART_WAIT:  cfg_q.restart_wait_ticks <= pwdata;
				REG_FAN_WAIT:      cfg_q.fan_wait_ticks <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux; temperatures come back sign-extended
	always_comb begin
		unique case (idx)
			REG_SELECTED_MODE: prdata = {30'd0, cfg_q.selected_mode};
			REG_UPPER_HYST:    prdata = 32'(cfg_q.upper_hysteresis_temp);
			REG_UPPER_SWITCH:  prdata = 32'(cfg_q.upper_switch_temp);
			REG_LOWER_HYST:    prdata = 32'(cfg_q.lower_hysteresis_temp);
			REG_LOWER_SWITCH:  prdata = 32'(cfg_q.lower_switch_temp);
			REG_RESTART_WAIT:  prdata = cfg_q.restart_wait_ticks;
			REG_FAN_WAIT:      prdata = cfg_q.fan_wait_ticks;
			default:           prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/thcc_ctrl.sv @@
`include "assert_macros.svh"

module thcc_ctrl
	import thcc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	op_mode_t    mode_q;
	logic        heater_q;
	logic        cooler_q;
	logic        fan_q;
	logic [31:0] last_off_q;

	op_mode_t    mode_d;
	logic        heater_d;
	logic        cooler_d;
	logic        fan_d;
	logic [31:0] last_off_d;
	logic [31:0] elapsed;
	logic        can_restart;
	logic        can_stop_fan;
	logic        hot;
	logic        cold;

	// one control pass: timers, mode selection, drive hysteresis
	always_comb begin
		last_off_d = (item.now_ticks < last_off_q) ? item.now_ticks : last_off_q;
		elapsed      = item.now_ticks - last_off_d;
		can_restart  = elapsed > cfg.restart_wait_ticks;
		can_stop_fan = elapsed > cfg.fan_wait_ticks;
		hot  = item.chamber_temp > cfg.upper_hysteresis_temp;
		cold = item.chamber_temp < cfg.lower_hysteresis_temp;
		mode_d   = mode_q;
		heater_d = heater_q;
		cooler_d = cooler_q;
		fan_d    = fan_q;

		// pick the operating mode
		case (cfg.selected_mode)
			SEL_AUTO: begin
				case (mode_q)
					OP_UNDEF: begin
						if (item.chamber_temp > cfg.upper_switch_temp)
							mode_d = OP_COOL;
						else if (item.chamber_temp < cfg.lower_switch_temp)
							mode_d = OP_HEAT;
					end
					OP_HEAT: begin
						if (item.chamber_temp > cfg.upper_switch_temp)
							mode_d = OP_COOL;
					end
					OP_COOL: begin
						if (item.chamber_temp < cfg.lower_switch_temp)
							mode_d = OP_HEAT;
					end
					default: mode_d = OP_UNDEF;
				endcase
			end
			SEL_COOL: mode_d = OP_COOL;
			default:  mode_d = OP_HEAT;
		endcase

		if (cfg.selected_mode == SEL_OFF) begin
			// off clears everything; a running cooler records its stop time
			mode_d = OP_UNDEF;
			if (cooler_q)
				last_off_d = item.now_ticks;
			heater_d = 1'b0;
			cooler_d = 1'b0;
			fan_d    = 1'b0;
		end else if (mode_d == OP_COOL) begin
			if (heater_q) begin
				last_off_d = item.now_ticks;
				heater_d   = 1'b0;
			end
			if (cooler_q && cold) begin
				last_off_d = item.now_ticks;
				cooler_d   = 1'b0;
			end else if (!cooler_q) begin
				if (can_restart && hot) begin
					cooler_d = 1'b1;
					fan_d    = 1'b1;
				end else if (fan_q && can_stop_fan) begin
					fan_d = 1'b0;
				end
			end
		end else if (mode_d == OP_HEAT) begin
			if (cooler_q) begin
				last_off_d = item.now_ticks;
				cooler_d   = 1'b0;
			end
			if (heater_q && hot) begin
				last_off_d = item.now_ticks;
				heater_d   = 1'b0;
			end else if (!heater_q) begin
				if (cold) begin
					heater_d = 1'b1;
					fan_d    = 1'b1;
				end else if (fan_q && can_stop_fan) begin
					fan_d = 1'b0;
				end
			end
		end else begin
			mode_d   = OP_UNDEF;
			heater_d = 1'b0;
			cooler_d = 1'b0;
			if (fan_q && can_stop_fan)
				fan_d = 1'b0;
		end
	end

	// controller state; it also serves as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= OP_UNDEF;
			heater_q   <= 1'b0;
			cooler_q   <= 1'b0;
			fan_q      <= 1'b0;
			last_off_q <= 32'd0;
		end else if (fire) begin
			mode_q     <= mode_d;
			heater_q   <= heater_d;
			cooler_q   <= cooler_d;
			fan_q      <= fan_d;
			last_off_q <= last_off_d;
		end
	end

	assign res.operating_mode = mode_q;
	assign res.fan_on         = fan_q;
	assign res.cooler_on      = cooler_q;
	assign res.heater_on      = heater_q;

	`ASSERT_ALWAYS(a_no_heat_and_cool, clk, arst_n, !(heater_q && cooler_q))
	`ASSERT_ALWAYS(a_fan_with_drive, clk, arst_n, !(heater_q || cooler_q) || fan_q)
	`ASSERT_NEXT(a_off_clears, clk, arst_n, fire && cfg.selected_mode == SEL_OFF,
		!heater_q && !cooler_q && !fan_q && mode_q == OP_UNDEF)
	`ASSERT_NEXT(a_heat_only_mode, clk, arst_n, fire && cfg.selected_mode == SEL_HEAT,
		mode_q == OP_HEAT && !cooler_q)

endmodule

@@ rtl/thermostat_heat_cool_controller.sv @@
// Heat/cool thermostat with hysteresis, cooler restart delay and fan run-on.
// Input stream: one word per control pass, s_axis_tdata carries the tick
// count and the signed chamber temperature (1/16 degree). Output stream: one
// word per pass with heater, cooler and fan drives and the operating mode.
// The input word is registered in the input register and the pass result in
// the controller state. Throughput: one word per cycle while m_axis_tready is
// high; the whole pass (32-bit elapsed-time subtract, two compares against the
// waits, temperature compares and the mode logic) sits between the two registers.
// The controller state doubles as the output register, so it only updates
// when the output slot is empty or being drained.
// When m_axis_tready is low the result holds; one more word is taken into
// the input register and then s_axis_tready drops until the output drains.
// Reset: configuration returns to heat-only mode with default thresholds,
// all drives off, operating mode undefined, last switch-off time zero.
// Configuration goes through the APB port (pready always high) and should
// be written only while no word is in flight.
module thermostat_heat_cool_controller
	import thcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [47:0]       s_axis_tdata,  // [31:0] now_ticks, [43:32] chamber_temp, pad
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // [0] heater_on, [1] cooler_on, [2] fan_on,
	                                         // [4:3] operating_mode, pad
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    out_valid_q;
	logic    fire;
	logic    accept;
	result_t res;

	assign pready = 1'b1;

	thcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// handshake: the pass runs when the output slot is free or being taken
	assign fire          = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | fire;
	assign accept        = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (fire)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// input word register
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.now_ticks    <= s_axis_tdata[31:0];
			item_s1.chamber_temp <= s_axis_tdata[43:32];
		end
	end

	thcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, res.operating_mode, res.fan_on, res.cooler_on,
		res.heater_on};

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import thcc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	// one queued control pass
	typedef struct {
		logic [31:0]        now;
		logic signed [11:0] temp;
		bit                 drain_first;   // hold off until every drive word is back
	} pass_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [47:0]       s_axis_tdata;   // [31:0] now_ticks, [43:32] chamber_temp, pad
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [7:0]        m_axis_tdata;   // [0] heater_on, [1] cooler_on, [2] fan_on,
	                                   // [4:3] operating_mode, pad
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	thermostat_heat_cool_controller uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// mirror of the register file
	sel_mode_t          sel_mode;
	logic signed [11:0] hyst_hi, switch_hi, hyst_lo, switch_lo;
	logic [31:0]        restart_wait, runon_wait;

	// mirror of the controller state
	op_mode_t    mode_q;
	logic        heat_q, cool_q, fan_q;
	logic [31:0] off_tick;

	pass_t   pass_q[$];
	result_t drive_q[$];
	int      words_sent, words_in, results_seen, err_cnt, settings_cnt, cycle_cnt;
	bit      no_gaps;

	// one control pass of the thermostat; updates the mirrored state
	function automatic result_t thermo_pass(logic [31:0] now, logic signed [11:0] temp);
		logic [31:0] elapsed;
		logic        may_restart, fan_may_stop;
		result_t     r;
		if (now < off_tick)
			off_tick = now;
		elapsed = now - off_tick;
		may_restart = elapsed > restart_wait;
		fan_may_stop = elapsed > runon_wait;
		if (sel_mode == SEL_OFF) begin
			if (cool_q)
				off_tick = now;
			mode_q = OP_UNDEF;
			heat_q = 1'b0;
			cool_q = 1'b0;
			fan_q = 1'b0;
		end else begin
			// pick the operating mode
			case (sel_mode)
				SEL_AUTO: begin
					case (mode_q)
						OP_UNDEF: begin
							if (temp > switch_hi) mode_q = OP_COOL;
							else if (temp < switch_lo) mode_q = OP_HEAT;
						end
						OP_HEAT: if (temp > switch_hi) mode_q = OP_COOL;
						OP_COOL: if (temp < switch_lo) mode_q = OP_HEAT;
						default: mode_q = OP_UNDEF;
					endcase
				end
				SEL_COOL: mode_q = OP_COOL;
				default: mode_q = OP_HEAT;
			endcase
			// drives with hysteresis, restart delay and fan run-on
			if (mode_q == OP_COOL) begin
				if (heat_q) begin
					off_tick = now;
					heat_q = 1'b0;
				end
				if (cool_q && temp < hyst_lo) begin
					off_tick = now;
					cool_q = 1'b0;
				end else if (!cool_q) begin
					if (may_restart && temp > hyst_hi) begin
						cool_q = 1'b1;
						fan_q = 1'b1;
					end else if (fan_q && fan_may_stop) begin
						fan_q = 1'b0;
					end
				end
			end else if (mode_q == OP_HEAT) begin
				if (cool_q) begin
					off_tick = now;
					cool_q = 1'b0;
				end
				if (heat_q && temp > hyst_hi) begin
					off_tick = now;
					heat_q = 1'b0;
				end else if (!heat_q) begin
					if (temp < hyst_lo) begin
						heat_q = 1'b1;
						fan_q = 1'b1;
					end else if (fan_q && fan_may_stop) begin
						fan_q = 1'b0;
					end
				end
			end else begin
				mode_q = OP_UNDEF;
				cool_q = 1'b0;
				heat_q = 1'b0;
				if (fan_q && fan_may_stop)
					fan_q = 1'b0;
			end
		end
		r.heater_on = heat_q;
		r.cooler_on = cool_q;
		r.fan_on = fan_q;
		r.operating_mode = mode_q;
		return r;
	endfunction

	function automatic int fit(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic void queue_pass(logic [31:0] now, int temp, bit drain_first);
		pass_t p;
		p.now = now;
		p.temp = temp[11:0];
		p.drain_first = drain_first;
		pass_q.push_back(p);
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		err_cnt++;
		if (err_cnt <= 40)
			$display("mismatch: %s on drive word %0d, got %0d, expected %0d",
				what, results_seen, got, want);
	endtask

	// APB write: setup then access; mirror updated at the write edge
	task automatic apb_write(reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_SELECTED_MODE: sel_mode = sel_mode_t'(data[1:0]);
			REG_UPPER_HYST:    hyst_hi = data[11:0];
			REG_UPPER_SWITCH:  switch_hi = data[11:0];
			REG_LOWER_HYST:    hyst_lo = data[11:0];
			REG_LOWER_SWITCH:  switch_lo = data[11:0];
			REG_RESTART_WAIT:  restart_wait = data;
			REG_FAN_WAIT:      runon_wait = data;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_setup(sel_mode_t m, int uh, int us, int lh, int ls,
		logic [31:0] rw, logic [31:0] fw);
		apb_write(REG_SELECTED_MODE, {30'd0, m});
		apb_write(REG_UPPER_HYST, uh);
		apb_write(REG_UPPER_SWITCH, us);
		apb_write(REG_LOWER_HYST, lh);
		apb_write(REG_LOWER_SWITCH, ls);
		apb_write(REG_RESTART_WAIT, rw);
		apb_write(REG_FAN_WAIT, fw);
		settings_cnt++;
	endtask

	task automatic wait_drained();
		while (pass_q.size() != 0 || words_in != words_sent || drive_q.size() != 0)
			@(posedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// input driver: holds a word until taken, gaps at random
	always @(negedge clk) begin : pass_driver
		pass_t nxt;
		if (words_in == words_sent) begin
			if (pass_q.size() != 0 && (no_gaps || $urandom_range(99) >= 17)
				&& !(pass_q[0].drain_first && drive_q.size() != 0)) begin
				nxt = pass_q.pop_front();
				s_axis_tdata <= {4'b0, nxt.temp, nxt.now};
				s_axis_tvalid <= 1'b1;
				words_sent++;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output side back-pressure
	always @(negedge clk)
		m_axis_tready <= no_gaps || ($urandom_range(99) >= 17);

	// monitor: check drive words, predict from accepted passes, watchdog
	always @(posedge clk) begin : drive_monitor
		result_t got, want;
		cycle_cnt++;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[4:0]);
				if (drive_q.size() == 0) begin
					flag_mismatch("drive word with nothing pending", int'(got), 0);
				end else begin
					want = drive_q.pop_front();
					if (got.heater_on != want.heater_on)
						flag_mismatch("heater_on", got.heater_on, want.heater_on);
					if (got.cooler_on != want.cooler_on)
						flag_mismatch("cooler_on", got.cooler_on, want.cooler_on);
					if (got.fan_on != want.fan_on)
						flag_mismatch("fan_on", got.fan_on, want.fan_on);
					if (got.operating_mode != want.operating_mode)
						flag_mismatch("operating_mode", int'(got.operating_mode),
							int'(want.operating_mode));
				end
				results_seen++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				words_in++;
				drive_q.push_back(thermo_pass(s_axis_tdata[31:0], s_axis_tdata[43:32]));
			end
		end
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d drive words pending",
				cycle_cnt, drive_q.size());
			$display("FAIL thermostat_heat_cool_controller");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		logic [31:0] tick_now, rw, fw;
		int          c, ls, lh, uh, us, walk, r, step_max;
		sel_mode_t   m;
		bit          df;

		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		no_gaps = 1'b0;
		words_sent = 0;
		words_in = 0;
		results_seen = 0;
		err_cnt = 0;
		settings_cnt = 1;
		cycle_cnt = 0;
		sel_mode = sel_mode_t'(RST_SELECTED_MODE);
		hyst_hi = RST_UPPER_HYST;
		switch_hi = RST_UPPER_SWITCH;
		hyst_lo = RST_LOWER_HYST;
		switch_lo = RST_LOWER_SWITCH;
		restart_wait = RST_RESTART_WAIT;
		runon_wait = RST_FAN_WAIT;
		mode_q = OP_UNDEF;
		heat_q = 1'b0;
		cool_q = 1'b0;
		fan_q = 1'b0;
		off_tick = '0;

		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// heat only at reset defaults: hysteresis, fan run-on edge, ticks going back
		queue_pass(32'd100, -2048, 0);
		queue_pass(32'd200, 2047, 0);
		queue_pass(32'd300, 300, 0);
		queue_pass(32'd300200, 300, 0);
		queue_pass(32'd300201, 300, 0);
		queue_pass(32'd50, 0, 0);
		queue_pass(32'hFFFF_FFFF, 400, 0);
		queue_pass(32'd0, 300, 0);
		wait_drained();

		// cool only, short delays: restart blocked, then allowed one tick past
		load_setup(SEL_COOL, 352, 368, 288, 272, 32'd10, 32'd20);
		queue_pass(32'd1000, 400, 0);
		queue_pass(32'd1005, 200, 0);
		queue_pass(32'd1010, 400, 0);
		queue_pass(32'd1015, 400, 0);
		queue_pass(32'd1016, 400, 0);
		queue_pass(32'd1020, 300, 0);
		wait_drained();

		// automatic: from cool mode, switch to heat, back to cool
		load_setup(SEL_AUTO, 352, 368, 288, 272, 32'd10, 32'd20);
		queue_pass(32'd2000, 300, 0);
		queue_pass(32'd2001, 500, 0);
		queue_pass(32'd2002, 260, 0);
		queue_pass(32'd2003, 2047, 0);
		queue_pass(32'd2020, 2047, 0);
		wait_drained();

		// off with the cooler running
		load_setup(SEL_OFF, 352, 368, 288, 272, 32'd10, 32'd20);
		queue_pass(32'd2021, 2047, 0);
		wait_drained();

		// random settings, temperature walking around the thresholds
		tick_now = 32'd5000;
		for (int ph = 0; ph < 12; ph++) begin
			if ($urandom_range(7) == 0) m = SEL_OFF;
			else m = sel_mode_t'($urandom_range(1, 3));
			if (ph == 1) m = SEL_AUTO;
			c = int'($urandom_range(2780)) - 880;
			if (ph == 2) c = -860;
			if (ph == 5) c = 1980;
			ls = fit(c - int'($urandom_range(40)), -880, 2000);
			lh = fit(c - int'($urandom_range(20)), -880, 2000);
			uh = fit(c + int'($urandom_range(20)), -880, 2000);
			us = fit(c + int'($urandom_range(40)), -880, 2000);
			if (ph == 2) begin
				ls = -880;
				lh = -880;
			end
			if (ph == 5) begin
				uh = 2000;
				us = 2000;
			end
			if (ph == 8) begin
				ls = int'($urandom_range(4095)) - 2048;
				lh = int'($urandom_range(4095)) - 2048;
				uh = int'($urandom_range(4095)) - 2048;
				us = int'($urandom_range(4095)) - 2048;
			end
			rw = $urandom_range(60);
			fw = $urandom_range(120);
			step_max = 25;
			if (ph == 0) begin
				rw = 32'd0;
				fw = 32'd0;
			end
			if (ph == 4) begin
				rw = 32'hFFFF_FFFF;
				fw = 32'hFFFF_FFFF;
			end
			if (ph == 7) begin
				rw = $urandom();
				fw = $urandom();
				step_max = 32'h4000_0000;
			end
			load_setup(m, uh, us, lh, ls, rw, fw);
			no_gaps = (ph == 3);
			walk = c;
			for (int k = 0; k < 100; k++) begin
				r = $urandom_range(99);
				if (r < 3) tick_now = tick_now - $urandom_range(1000);
				else if (r < 5) tick_now = $urandom();
				else tick_now = tick_now + $urandom_range(step_max);
				walk = walk + int'($urandom_range(24)) - 12;
				if (walk > c + 80) walk = walk - 20;
				if (walk < c - 80) walk = walk + 20;
				walk = fit(walk, -2048, 2047);
				df = ($urandom_range(49) == 0) || (ph == 6 && k == 50);
				if ($urandom_range(9) == 0)
					queue_pass(tick_now, int'($urandom_range(4095)) - 2048, df);
				else
					queue_pass(tick_now, walk, df);
			end
			wait_drained();
		end
		no_gaps = 1'b0;

		wait_drained();
		repeat (5) @(posedge clk);
		$display("%0d control passes checked under %0d register settings: all modes,",
			results_seen, settings_cnt);
		$display("threshold and delay extremes, tick wrap and rollback, %0d mismatches",
			err_cnt);
		if (err_cnt == 0) begin
			$display("PASS thermostat_heat_cool_controller");
		end else begin
			$display("FAIL thermostat_heat_cool_controller");
		end
		$finish;
	end

endmodule
